// ===== rtl/ghp_pkg.sv =====
// Shared types, codes and helpers for the gzip header parser.
package ghp_pkg;

   // Default width of the byte position; its counter has one extra bit
   localparam int unsigned OFFSET_BITS_DEFAULT = 16;

   localparam int unsigned PHASE_WIDTH   = 4;
   localparam int unsigned VERDICT_WIDTH = 3;
   localparam int unsigned OFFSET_WIDTH  = 16;
   localparam int unsigned FLAGS_WIDTH   = 5;
   localparam int unsigned SKIP_WIDTH    = 16;
   localparam int unsigned RSP_WIDTH     = 32;

   // Header constants
   localparam logic [7:0] MAGIC_A        = 8'h1f;
   localparam logic [7:0] MAGIC_B        = 8'h8b;
   localparam logic [7:0] METHOD_DEFLATE = 8'h08;
   localparam logic [7:0] FL_HCRC        = 8'h02;
   localparam logic [7:0] FL_EXTRA       = 8'h04;
   localparam logic [7:0] FL_NAME        = 8'h08;
   localparam logic [7:0] FL_COMMENT     = 8'h10;
   localparam logic [7:0] FL_RESERVED    = 8'hE0;
   localparam logic [SKIP_WIDTH-1:0] FIXED_SKIP = 16'd6;
   localparam logic [SKIP_WIDTH-1:0] HCRC_SKIP  = 16'd2;

   // Parse phases
   localparam logic [PHASE_WIDTH-1:0] PH_MAG1    = 4'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_MAG2    = 4'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_METHOD  = 4'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_FLAGS   = 4'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_FIXED   = 4'd4;
   localparam logic [PHASE_WIDTH-1:0] PH_XLO     = 4'd5;
   localparam logic [PHASE_WIDTH-1:0] PH_XHI     = 4'd6;
   localparam logic [PHASE_WIDTH-1:0] PH_EXTRA   = 4'd7;
   localparam logic [PHASE_WIDTH-1:0] PH_NAME    = 4'd8;
   localparam logic [PHASE_WIDTH-1:0] PH_COMMENT = 4'd9;
   localparam logic [PHASE_WIDTH-1:0] PH_HCRC    = 4'd10;
   localparam logic [PHASE_WIDTH-1:0] PH_DATA    = 4'd11;

   // Verdict codes
   localparam logic [VERDICT_WIDTH-1:0] V_OK       = 3'd0;
   localparam logic [VERDICT_WIDTH-1:0] V_MAGIC    = 3'd1;
   localparam logic [VERDICT_WIDTH-1:0] V_METHOD   = 3'd2;
   localparam logic [VERDICT_WIDTH-1:0] V_RESERVED = 3'd3;
   localparam logic [VERDICT_WIDTH-1:0] V_TRUNC    = 3'd4;
   localparam logic [VERDICT_WIDTH-1:0] V_LONG     = 3'd5;

   // Parser state apart from the byte position
   typedef struct packed {
      logic [PHASE_WIDTH-1:0] phase;
      logic [7:0]             flags;
      logic [SKIP_WIDTH-1:0]  skip;
      logic                   given;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase: PH_MAG1, flags: 8'h00, skip: '0, given: 1'b0};

   // Result of one step
   typedef struct packed {
      logic                     fire;
      logic                     ok;
      logic [VERDICT_WIDTH-1:0] verdict;
      logic [OFFSET_WIDTH-1:0]  offset;
      logic [FLAGS_WIDTH-1:0]   flags;
   } result_type;

   // Pick the next optional section after the one just finished
   function automatic logic [PHASE_WIDTH-1:0] next_after(
      input logic [PHASE_WIDTH-1:0] done,
      input logic [7:0]             flags);
      logic [PHASE_WIDTH-1:0] nxt;
      nxt = PH_DATA;
      if (done < PH_XLO && (flags & FL_EXTRA) != 8'h00) begin
         nxt = PH_XLO;
      end else if (done < PH_NAME && (flags & FL_NAME) != 8'h00) begin
         nxt = PH_NAME;
      end else if (done < PH_COMMENT && (flags & FL_COMMENT) != 8'h00) begin
         nxt = PH_COMMENT;
      end else if (done < PH_HCRC && (flags & FL_HCRC) != 8'h00) begin
         nxt = PH_HCRC;
      end
      return nxt;
   endfunction

endpackage

// ===== rtl/ghp_step.sv =====
// Next-state and verdict logic for one header byte.
module ghp_step #(
   parameter int unsigned OFFSET_BITS = ghp_pkg::OFFSET_BITS_DEFAULT
) (
   input  ghp_pkg::state_type    cur,
   input  logic [OFFSET_BITS:0]  idx,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output ghp_pkg::state_type    nxt,
   output logic [OFFSET_BITS:0]  idx_in,
   output ghp_pkg::result_type   res
);

   logic                                too_long;
   logic                                fire;
   logic [ghp_pkg::VERDICT_WIDTH-1:0]   verdict;
   logic [ghp_pkg::SKIP_WIDTH-1:0]      skip_dec;
   logic [ghp_pkg::SKIP_WIDTH-1:0]      skip_hi;
   logic [7:0]                          flags_seen;

   assign too_long = idx[OFFSET_BITS];
   assign skip_dec = cur.skip - ghp_pkg::SKIP_WIDTH'(1);
   assign skip_hi  = {data_byte, cur.skip[7:0]};

   always_comb begin
      nxt        = cur;
      idx_in     = idx;
      fire       = 1'b0;
      verdict    = ghp_pkg::V_OK;
      flags_seen = cur.flags;

      // Advance the parser while no verdict has been given
      if (!cur.given) begin
         if (too_long) begin
            fire    = 1'b1;
            verdict = ghp_pkg::V_LONG;
         end else begin
            unique case (cur.phase)
               ghp_pkg::PH_MAG1: begin
                  if (data_byte != ghp_pkg::MAGIC_A) begin
                     fire    = 1'b1;
                     verdict = ghp_pkg::V_MAGIC;
                  end else begin
                     nxt.phase = ghp_pkg::PH_MAG2;
                  end
               end
               ghp_pkg::PH_MAG2: begin
                  if (data_byte != ghp_pkg::MAGIC_B) begin
                     fire    = 1'b1;
                     verdict = ghp_pkg::V_MAGIC;
                  end else begin
                     nxt.phase = ghp_pkg::PH_METHOD;
                  end
               end
               ghp_pkg::PH_METHOD: begin
                  if (data_byte != ghp_pkg::METHOD_DEFLATE) begin
                     fire    = 1'b1;
                     verdict = ghp_pkg::V_METHOD;
                  end else begin
                     nxt.phase = ghp_pkg::PH_FLAGS;
                  end
               end
               ghp_pkg::PH_FLAGS: begin
                  nxt.flags  = data_byte;
                  flags_seen = data_byte;
                  if ((data_byte & ghp_pkg::FL_RESERVED) != 8'h00) begin
                     fire    = 1'b1;
                     verdict = ghp_pkg::V_RESERVED;
                  end else begin
                     nxt.skip  = ghp_pkg::FIXED_SKIP;
                     nxt.phase = ghp_pkg::PH_FIXED;
                  end
               end
               ghp_pkg::PH_FIXED: begin
                  nxt.skip = skip_dec;
                  if (skip_dec == '0) begin
                     nxt.phase = ghp_pkg::next_after(ghp_pkg::PH_FIXED, cur.flags);
                  end
               end
               ghp_pkg::PH_XLO: begin
                  nxt.skip  = ghp_pkg::SKIP_WIDTH'(data_byte);
                  nxt.phase = ghp_pkg::PH_XHI;
               end
               ghp_pkg::PH_XHI: begin
                  nxt.skip = skip_hi;
                  if (skip_hi == '0) begin
                     nxt.phase = ghp_pkg::next_after(ghp_pkg::PH_EXTRA, cur.flags);
                  end else begin
                     nxt.phase = ghp_pkg::PH_EXTRA;
                  end
               end
               ghp_pkg::PH_EXTRA: begin
                  nxt.skip = skip_dec;
                  if (skip_dec == '0) begin
                     nxt.phase = ghp_pkg::next_after(ghp_pkg::PH_EXTRA, cur.flags);
                  end
               end
               ghp_pkg::PH_NAME: begin
                  if (data_byte == 8'h00) begin
                     nxt.phase = ghp_pkg::next_after(ghp_pkg::PH_NAME, cur.flags);
                  end
               end
               ghp_pkg::PH_COMMENT: begin
                  if (data_byte == 8'h00) begin
                     nxt.phase = ghp_pkg::next_after(ghp_pkg::PH_COMMENT, cur.flags);
                  end
               end
               ghp_pkg::PH_HCRC: begin
                  nxt.skip = skip_dec;
                  if (skip_dec == '0) begin
                     nxt.phase = ghp_pkg::PH_DATA;
                  end
               end
               default: begin
                  fire    = 1'b1;
                  verdict = ghp_pkg::V_OK;
               end
            endcase
            // The only way into the CRC skip loads its two-byte count
            if (nxt.phase == ghp_pkg::PH_HCRC && cur.phase != ghp_pkg::PH_HCRC) begin
               nxt.skip = ghp_pkg::HCRC_SKIP;
            end
            idx_in = idx + (OFFSET_BITS + 1)'(1);
         end
         if (fire) begin
            nxt.given = 1'b1;
         end
      end

      // Close the buffer on its final byte and rearm
      if (last_byte) begin
         if (!nxt.given) begin
            fire    = 1'b1;
            verdict = ghp_pkg::V_TRUNC;
         end
         nxt    = ghp_pkg::STATE_RESET;
         idx_in = '0;
      end

      res.fire    = fire;
      res.ok      = (verdict == ghp_pkg::V_OK);
      res.verdict = verdict;
      res.offset  = (verdict == ghp_pkg::V_OK) ?
                    ghp_pkg::OFFSET_WIDTH'(idx[OFFSET_BITS-1:0]) : '0;
      res.flags   = flags_seen[ghp_pkg::FLAGS_WIDTH-1:0];
   end

endmodule

// ===== rtl/gzip_header_parser_unit.sv =====
// Top level of the gzip member header parser.
//
// Takes one buffer byte per item on the req_ channel, tlast on the final byte, and gives
// at most one verdict item per buffer on the rsp_ channel. The parser state and byte
// position update in the cycle the byte is accepted, and a verdict goes into the
// result register at the same edge, so a byte can be accepted in every cycle while
// the result register is empty or being drained. The parser checks the
// magic, method 8 and reserved flag bits, skips the fixed fields, the extra field, name,
// comment and header CRC, and reports success with the index of the first data byte.
// A buffer that ends without a verdict reports truncated; a byte at index
// 2**OFFSET_BITS or later reports too long. Bytes after a verdict are dropped up to tlast.
module gzip_header_parser_unit #(
   parameter int unsigned OFFSET_BITS = ghp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] data_byte
   input  logic                          req_tlast,   // last_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [0] header_ok, [3:1] verdict, [19:4] data_offset, [24:20] header_flags, rest zero
   output logic [ghp_pkg::RSP_WIDTH-1:0] rsp_tdata
);

   ghp_pkg::state_type         state_ff, state_in;
   logic [OFFSET_BITS:0]       idx_ff, idx_in;
   ghp_pkg::result_type        res;
   logic                       rsp_valid_ff;
   logic [ghp_pkg::RSP_WIDTH-1:0] rsp_data_ff;
   logic                       accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   ghp_step #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_step (
      .cur       (state_ff),
      .idx       (idx_ff),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .nxt       (state_in),
      .idx_in    (idx_in),
      .res       (res)
   );

   // Advance parser state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ghp_pkg::STATE_RESET;
         idx_ff   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // Hold the verdict item until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && res.fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res.fire) begin
         rsp_data_ff <= ghp_pkg::RSP_WIDTH'({res.flags, res.offset, res.verdict, res.ok});
      end
   end

endmodule

// ===== verif/gzip_header_parser_unit_test.sv =====
// Self-checking testbench for the gzip member header parser unit.
module gzip_header_parser_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned INDEX_SPAN     = 1 << ghp_pkg::OFFSET_BITS_DEFAULT;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned TAIL_CYCLES    = 20;
   localparam logic [7:0]  FL_TEXT        = 8'h01;

   // One byte of a buffer as offered on the request channel
   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } stream_byte_type;

   // One verdict as it should leave the response channel
   typedef struct packed {
      logic                              ok;
      logic [ghp_pkg::VERDICT_WIDTH-1:0] verdict;
      logic [ghp_pkg::OFFSET_WIDTH-1:0]  offset;
      logic [ghp_pkg::FLAGS_WIDTH-1:0]   flags;
   } verdict_item_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata = 8'h00;
   logic                          req_tlast = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [ghp_pkg::RSP_WIDTH-1:0] rsp_tdata;

   stream_byte_type  byte_queue[$];
   verdict_item_type verdict_queue[$];
   logic [7:0]       frame_bytes[$];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_asked     = 0;
   int unsigned hold_seen      = 0;
   int unsigned hold_left      = 0;
   int unsigned idle_cycles    = 0;
   int unsigned error_count    = 0;
   bit          req_taken      = 1'b0;

   // Shadow parser state
   logic [ghp_pkg::PHASE_WIDTH-1:0] pp_phase;
   int unsigned                     pp_index;
   logic [7:0]                      pp_flags;
   logic [ghp_pkg::SKIP_WIDTH-1:0]  pp_skip;
   bit                              pp_done;

   gzip_header_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Return the shadow parser to its idle state
   task automatic rearm_parser();
      pp_phase = ghp_pkg::PH_MAG1;
      pp_index = 0;
      pp_flags = 8'h00;
      pp_skip  = '0;
      pp_done  = 1'b0;
   endtask

   task automatic post_verdict(input logic [ghp_pkg::VERDICT_WIDTH-1:0] code,
                               input int unsigned at);
      verdict_item_type v;
      v.ok      = (code == ghp_pkg::V_OK);
      v.verdict = code;
      v.offset  = (code == ghp_pkg::V_OK) ? at[ghp_pkg::OFFSET_WIDTH-1:0] : '0;
      v.flags   = pp_flags[ghp_pkg::FLAGS_WIDTH-1:0];
      verdict_queue.push_back(v);
      pp_done = 1'b1;
   endtask

   // Move on to the next optional section the flags ask for
   task automatic enter_after(input logic [ghp_pkg::PHASE_WIDTH-1:0] finished);
      if (finished < ghp_pkg::PH_XLO && (pp_flags & ghp_pkg::FL_EXTRA) != 8'h00) begin
         pp_phase = ghp_pkg::PH_XLO;
      end else if (finished < ghp_pkg::PH_NAME && (pp_flags & ghp_pkg::FL_NAME) != 8'h00) begin
         pp_phase = ghp_pkg::PH_NAME;
      end else if (finished < ghp_pkg::PH_COMMENT &&
                   (pp_flags & ghp_pkg::FL_COMMENT) != 8'h00) begin
         pp_phase = ghp_pkg::PH_COMMENT;
      end else if (finished < ghp_pkg::PH_HCRC && (pp_flags & ghp_pkg::FL_HCRC) != 8'h00) begin
         pp_phase = ghp_pkg::PH_HCRC;
         pp_skip  = ghp_pkg::HCRC_SKIP;
      end else begin
         pp_phase = ghp_pkg::PH_DATA;
      end
   endtask

   // Advance the shadow parser by one accepted byte
   task automatic parse_byte(input logic [7:0] b, input logic last);
      if (!pp_done) begin
         if (pp_index >= INDEX_SPAN) begin
            post_verdict(ghp_pkg::V_LONG, 0);
         end else begin
            case (pp_phase)
               ghp_pkg::PH_MAG1: begin
                  if (b != ghp_pkg::MAGIC_A) post_verdict(ghp_pkg::V_MAGIC, 0);
                  else pp_phase = ghp_pkg::PH_MAG2;
               end
               ghp_pkg::PH_MAG2: begin
                  if (b != ghp_pkg::MAGIC_B) post_verdict(ghp_pkg::V_MAGIC, 0);
                  else pp_phase = ghp_pkg::PH_METHOD;
               end
               ghp_pkg::PH_METHOD: begin
                  if (b != ghp_pkg::METHOD_DEFLATE) post_verdict(ghp_pkg::V_METHOD, 0);
                  else pp_phase = ghp_pkg::PH_FLAGS;
               end
               ghp_pkg::PH_FLAGS: begin
                  pp_flags = b;
                  if ((b & ghp_pkg::FL_RESERVED) != 8'h00) begin
                     post_verdict(ghp_pkg::V_RESERVED, 0);
                  end else begin
                     pp_skip  = ghp_pkg::FIXED_SKIP;
                     pp_phase = ghp_pkg::PH_FIXED;
                  end
               end
               ghp_pkg::PH_FIXED: begin
                  pp_skip = pp_skip - 1'b1;
                  if (pp_skip == '0) enter_after(ghp_pkg::PH_FIXED);
               end
               ghp_pkg::PH_XLO: begin
                  pp_skip  = {8'h00, b};
                  pp_phase = ghp_pkg::PH_XHI;
               end
               ghp_pkg::PH_XHI: begin
                  pp_skip = {b, pp_skip[7:0]};
                  if (pp_skip == '0) enter_after(ghp_pkg::PH_EXTRA);
                  else pp_phase = ghp_pkg::PH_EXTRA;
               end
               ghp_pkg::PH_EXTRA: begin
                  pp_skip = pp_skip - 1'b1;
                  if (pp_skip == '0) enter_after(ghp_pkg::PH_EXTRA);
               end
               ghp_pkg::PH_NAME: begin
                  if (b == 8'h00) enter_after(ghp_pkg::PH_NAME);
               end
               ghp_pkg::PH_COMMENT: begin
                  if (b == 8'h00) enter_after(ghp_pkg::PH_COMMENT);
               end
               ghp_pkg::PH_HCRC: begin
                  pp_skip = pp_skip - 1'b1;
                  if (pp_skip == '0) pp_phase = ghp_pkg::PH_DATA;
               end
               default: begin
                  post_verdict(ghp_pkg::V_OK, pp_index);
               end
            endcase
         end
         if (pp_index < INDEX_SPAN) pp_index++;
      end
      // The final byte closes the buffer and rearms
      if (last) begin
         if (!pp_done) post_verdict(ghp_pkg::V_TRUNC, 0);
         rearm_parser();
      end
   endtask

   // Assemble one gzip header with the given sections, then some data bytes
   task automatic build_frame(input logic [7:0] flags, input int xlen, input int name_len,
                              input int comment_len, input int data_len);
      frame_bytes = '{ghp_pkg::MAGIC_A, ghp_pkg::MAGIC_B, ghp_pkg::METHOD_DEFLATE, flags};
      repeat (6) frame_bytes.push_back(8'($urandom));
      if ((flags & ghp_pkg::FL_EXTRA) != 8'h00) begin
         frame_bytes.push_back(xlen[7:0]);
         frame_bytes.push_back(xlen[15:8]);
         repeat (xlen) frame_bytes.push_back(8'($urandom));
      end
      if ((flags & ghp_pkg::FL_NAME) != 8'h00) begin
         repeat (name_len) frame_bytes.push_back(8'($urandom_range(1, 255)));
         frame_bytes.push_back(8'h00);
      end
      if ((flags & ghp_pkg::FL_COMMENT) != 8'h00) begin
         repeat (comment_len) frame_bytes.push_back(8'($urandom_range(1, 255)));
         frame_bytes.push_back(8'h00);
      end
      if ((flags & ghp_pkg::FL_HCRC) != 8'h00) begin
         repeat (2) frame_bytes.push_back(8'($urandom));
      end
      repeat (data_len) frame_bytes.push_back(8'($urandom));
   endtask

   // Hand the assembled buffer to the driver, marking its final byte
   task automatic queue_frame();
      stream_byte_type sb;
      foreach (frame_bytes[i]) begin
         sb.value = frame_bytes[i];
         sb.last  = (i == frame_bytes.size() - 1);
         byte_queue.push_back(sb);
      end
   endtask

   // Wait until every byte is taken and every verdict has come back
   task automatic settle();
      while (byte_queue.size() != 0 || req_tvalid || verdict_queue.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Mostly well-formed headers with random content, some cut, corrupted or noise
   task automatic random_traffic(input int item_goal);
      int counted;
      int data_len;
      int cut;
      int pick;
      counted = 0;
      while (counted < item_goal) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 5)) frame_bytes.push_back(8'($urandom));
            if ($urandom_range(1) == 1) frame_bytes[0] = ghp_pkg::MAGIC_A;
         end else begin
            data_len = $urandom_range(1, 3);
            build_frame(8'($urandom_range(0, 31)),
                        ($urandom_range(99) < 85) ? $urandom_range(0, 6)
                                                  : $urandom_range(7, 120),
                        $urandom_range(0, 5), $urandom_range(0, 5), data_len);
            pick = $urandom_range(99);
            if (pick < 12) begin
               cut = $urandom_range(1, frame_bytes.size() - 1);
               frame_bytes = frame_bytes[0:cut-1];
            end else if (pick < 16) begin
               cut = $urandom_range(0, 1);
               frame_bytes[cut] = frame_bytes[cut] ^ 8'($urandom_range(1, 255));
            end else if (pick < 20) begin
               frame_bytes[2] = frame_bytes[2] ^ 8'($urandom_range(1, 255));
            end else if (pick < 25) begin
               frame_bytes[3] = frame_bytes[3] | (8'h20 << $urandom_range(0, 2))
                                | (8'($urandom) & ghp_pkg::FL_RESERVED);
            end
         end
         counted += frame_bytes.size();
         queue_frame();
      end
   endtask

   // Offer the next byte once the current one is taken, idling at random
   always @(negedge clock) begin : drive_req
      stream_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = byte_queue.pop_front();
            req_tdata  <= nxt.value;
            req_tlast  <= nxt.last;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Stall the response channel at random, or for a long hold when asked
   always @(negedge clock) begin : drive_rsp
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Sample both channels, check verdicts and predict new ones
   always @(posedge clock) begin : watch_ports
      verdict_item_type want;
      bit               rsp_taken;
      if (reset) begin
         rearm_parser();
         req_taken   = 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken = req_tvalid && req_tready;
         rsp_taken = rsp_tvalid && rsp_tready;
         if (rsp_taken) begin
            if (verdict_queue.size() == 0) begin
               flag_mismatch("unexpected verdict item", rsp_tdata, '0);
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_tdata[0] !== want.ok)
                  flag_mismatch("header_ok", rsp_tdata[0], want.ok);
               if (rsp_tdata[3:1] !== want.verdict)
                  flag_mismatch("verdict", rsp_tdata[3:1], want.verdict);
               if (rsp_tdata[19:4] !== want.offset)
                  flag_mismatch("data_offset", rsp_tdata[19:4], want.offset);
               if (rsp_tdata[24:20] !== want.flags)
                  flag_mismatch("header_flags", rsp_tdata[24:20], want.flags);
               if (rsp_tdata[ghp_pkg::RSP_WIDTH-1:25] !== '0)
                  flag_mismatch("padding", rsp_tdata[ghp_pkg::RSP_WIDTH-1:25], '0);
            end
         end
         if (req_taken) parse_byte(req_tdata, req_tlast);
         if (req_taken || rsp_taken) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   // End the run if the channels stop moving
   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("** gzip_header_parser_unit: FAILED **");
      $finish;
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: magic failures, one-byte buffers
      frame_bytes = '{8'h00};
      queue_frame();
      frame_bytes = '{8'hff};
      queue_frame();
      frame_bytes = '{ghp_pkg::MAGIC_A, 8'h8c, 8'hff, 8'hff};
      queue_frame();
      frame_bytes = '{ghp_pkg::MAGIC_A};
      queue_frame();
      // Bad method, then bad method together with reserved flags
      build_frame(8'h00, 0, 0, 0, 1);
      frame_bytes[2] = 8'h07;
      queue_frame();
      build_frame(8'h00, 0, 0, 0, 1);
      frame_bytes[2] = 8'h09;
      frame_bytes[3] = ghp_pkg::FL_RESERVED;
      queue_frame();
      // Each reserved flag bit alone
      for (int k = 0; k < 3; k++) begin
         build_frame(8'h20 << k, 0, 0, 0, 1);
         queue_frame();
      end
      // Smallest good header with the verdict on the final byte, then text flag only
      build_frame(8'h00, 0, 0, 0, 1);
      queue_frame();
      build_frame(FL_TEXT, 0, 0, 0, 3);
      queue_frame();
      // All sections, zero extra length; then a short extra field
      build_frame(8'h1f, 0, 3, 2, 2);
      queue_frame();
      build_frame(ghp_pkg::FL_EXTRA | ghp_pkg::FL_HCRC, 3, 0, 0, 1);
      queue_frame();
      // Buffers cut off in the extra field, name, just past the comment, in the CRC and before any data
      build_frame(ghp_pkg::FL_EXTRA, 5, 0, 0, 1);
      frame_bytes = frame_bytes[0:13];
      queue_frame();
      build_frame(ghp_pkg::FL_NAME, 0, 4, 0, 1);
      frame_bytes = frame_bytes[0:11];
      queue_frame();
      build_frame(ghp_pkg::FL_COMMENT, 0, 0, 4, 1);
      frame_bytes = frame_bytes[0:14];
      queue_frame();
      build_frame(ghp_pkg::FL_HCRC, 0, 0, 0, 1);
      frame_bytes = frame_bytes[0:10];
      queue_frame();
      build_frame(8'h00, 0, 0, 0, 1);
      frame_bytes = frame_bytes[0:9];
      queue_frame();
      settle();

      // Hold the response side while short buffers keep coming
      hold_asked++;
      repeat (60) begin
         frame_bytes = '{8'($urandom_range(0, 30))};
         queue_frame();
      end
      settle();

      // Random traffic under each idling mix
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_traffic(325);
      settle();
      send_idle_pct = 80;
      random_traffic(325);
      settle();
      send_idle_pct  = 0;
      recv_stall_pct = 80;
      random_traffic(325);
      settle();
      send_idle_pct  = 24;
      recv_stall_pct = 24;
      random_traffic(325);
      settle();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("** gzip_header_parser_unit: PASSED **");
      end else begin
         $display("** gzip_header_parser_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ghp_pkg.sv
rtl/ghp_step.sv
rtl/gzip_header_parser_unit.sv
verif/gzip_header_parser_unit_test.sv
